// File: hdl/sts_pkg.sv
// Shared types and codes for the software timer scheduler.
package sts_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int TAG_W   = 8;
    localparam int OSLOT_W = 4;
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CREATED   = 2'd0,
        KIND_NOFREE    = 2'd1,
        KIND_CANCELLED = 2'd2,
        KIND_EXPIRED   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE,
        ST_OUT
    } state_t;

    // Cell-chain candidate: earliest due slot seen so far.
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] dl;
        logic [6:0]        idx;
    } cand_t;

    // Per-cycle command to the cell row.
    typedef struct packed {
        logic              create;
        logic              fire;
        logic              cancel;
        logic [6:0]        sel;
        logic [TIME_W-1:0] now;
    } cell_ctl_t;

endpackage

// File: hdl/sts_cell.sv
// One timer slot cell: holds slot state and passes the scan candidate along.
module sts_cell
    import sts_pkg::*;
#(
    parameter logic [6:0] INDEX = 7'd0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [TIME_W-1:0] interval,
    input  logic [COUNT_W-1:0] repeat_count,
    input  logic [TAG_W-1:0]  target,
    input  logic [TAG_W-1:0]  event_code,
    input  logic              scan_en,
    input  logic              due_in,
    input  logic              free_in,
    output logic              free_out,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    output logic              active,
    output logic              due,
    output logic [TAG_W-1:0]  tgt,
    output logic [TAG_W-1:0]  evt
);

    logic               active_reg, active_next;
    logic               due_reg, due_next;
    logic [TIME_W-1:0]  dl_reg, dl_next;
    logic [TIME_W-1:0]  per_reg, per_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [TAG_W-1:0]   tgt_reg, tgt_next;
    logic [TAG_W-1:0]   evt_reg, evt_next;
    cand_t              cand_reg, cand_next;
    logic [COUNT_W-1:0] rem_dec;
    logic               mine;
    logic               better;

    assign mine = (ctl.sel == INDEX);
    assign free_out = free_in & active_reg;
    assign rem_dec = (!rem_reg[COUNT_W-1] && rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign better = due_reg && (!cand_in.found || dl_reg < cand_in.dl);

    // hand the candidate to the next cell through a register
    always_comb
    begin
        cand_next = cand_in;
        if (better)
        begin
            cand_next.found = 1'b1;
            cand_next.dl    = dl_reg;
            cand_next.idx   = INDEX;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        due_next    = due_reg;
        dl_next     = dl_reg;
        per_next    = per_reg;
        rem_next    = rem_reg;
        tgt_next    = tgt_reg;
        evt_next    = evt_reg;
        if (scan_en)
        begin
            // latch the due set once, at the start of the tick
            due_next = due_in & active_reg & (dl_reg <= ctl.now);
        end
        if (ctl.create && mine)
        begin
            active_next = 1'b1;
            per_next    = interval;
            dl_next     = ctl.now + interval;
            rem_next    = repeat_count;
            tgt_next    = target;
            evt_next    = event_code;
        end
        if (ctl.cancel && mine)
        begin
            active_next = 1'b0;
        end
        if (ctl.fire && mine)
        begin
            due_next = 1'b0;
            rem_next = rem_dec;
            if (rem_dec != '0)
            begin
                dl_next = ctl.now + per_reg;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            due_reg    <= 1'b0;
            cand_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            due_reg    <= due_next;
            cand_reg   <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg  <= dl_next;
        per_reg <= per_next;
        rem_reg <= rem_next;
        tgt_reg <= tgt_next;
        evt_reg <= evt_next;
    end

    assign cand_out = cand_reg;
    assign active   = active_reg;
    assign due      = due_reg;
    assign tgt      = tgt_reg;
    assign evt      = evt_reg;

endmodule

// File: hdl/software_timer_scheduler.sv
// Top level of the software timer scheduler: control and a row of slot cells.
//
//  channel | valid    | ready    | payload
//  input   | in_valid | in_ready | command slot interval repeat_count target event_code
//  result  | out_valid| out_ready| kind out_slot out_target out_event last
//
// Create and cancel are taken in the accept cycle and give one result in ST_OUT.
// A tick is taken, then for each expiry the candidate moves one cell per cycle
// through the row in ST_SCAN, the earliest due slot fires in ST_FIRE and its result
// goes out in ST_OUT. With nothing due a tick ends after ST_FIRE with no result.
// Reset clears the tick counter and all active bits; slot contents stay unset.
// A stalled result holds the block; the next item is taken once it leaves.
module software_timer_scheduler
    import sts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [3:0]          slot,
    input  logic [TIME_W-1:0]   interval,
    input  logic signed [COUNT_W-1:0] repeat_count,
    input  logic [TAG_W-1:0]    target,
    input  logic [TAG_W-1:0]    event_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic [3:0]          out_slot,
    output logic [TAG_W-1:0]    out_target,
    output logic [TAG_W-1:0]    out_event,
    output logic                last
);

    state_t state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [6:0]  scan_reg, scan_next;
    cand_t       best;
    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  oslot_reg;
    logic [TAG_W-1:0] otgt_reg, oevt_reg;
    logic        last_reg;
    logic        acc;
    cell_ctl_t   ctl;
    logic        scan_en;
    logic        more_due;
    logic        last_flag;

    cand_t       cand [TIMER_SLOTS+1];
    logic        freec [TIMER_SLOTS+1];
    logic [TIMER_SLOTS-1:0] act;
    logic [TIMER_SLOTS-1:0] dues;
    logic [TAG_W-1:0] tgts [TIMER_SLOTS];
    logic [TAG_W-1:0] evts [TIMER_SLOTS];
    logic [6:0]  free_idx;
    logic        any_free;

    assign acc = in_valid && in_ready;
    assign cand[0]  = '0;
    assign freec[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            sts_cell #(.INDEX(7'(g))) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .interval(interval), .repeat_count(repeat_count),
                .target(target), .event_code(event_code),
                .scan_en(scan_en), .due_in(1'b1),
                .free_in(freec[g]), .free_out(freec[g+1]),
                .cand_in(cand[g]), .cand_out(cand[g+1]),
                .active(act[g]), .due(dues[g]), .tgt(tgts[g]), .evt(evts[g])
            );
        end
    endgenerate

    // the last cell holds the earliest due slot after a full pass of the row
    assign best = cand[TIMER_SLOTS];

    // lowest free slot: first cell whose predecessors are all active
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = TIMER_SLOTS-1; i >= 0; i--)
        begin
            if (freec[i] && !act[i])
            begin
                free_idx = 7'(i);
                any_free = 1'b1;
            end
        end
    end

    assign scan_en = acc && (command == CMD_TICK);

    always_comb
    begin
        ctl.create = acc && (command == CMD_CREATE) && any_free;
        ctl.cancel = acc && (command == CMD_CANCEL);
        ctl.fire   = (state_reg == ST_FIRE) && best.found;
        ctl.sel    = ctl.fire ? best.idx
                   : (ctl.create ? free_idx : {3'b000, slot});
        ctl.now    = scan_en ? now_reg + 1'b1 : now_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && command == CMD_TICK)
                    state_next = ST_SCAN;
                else if (acc && command != CMD_NONE)
                    state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                if (scan_reg == 7'(TIMER_SLOTS-1))
                    state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                if (best.found)
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = last ? ST_IDLE : ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        now_next  = scan_en ? now_reg + 1'b1 : now_reg;
        cnt_next  = scan_en ? '0 : (ctl.fire ? cnt_reg + 1'b1 : cnt_reg);
        scan_next = (state_reg == ST_SCAN) ? scan_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            cnt_reg   <= '0;
            scan_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= scan_next;
            if (state_next == ST_OUT && state_reg != ST_OUT)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // capture the fired slot's tags before the cell frees it
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            kind_reg  <= KIND_EXPIRED;
            oslot_reg <= best.idx[3:0];
            otgt_reg  <= tgts[best.idx[$clog2(TIMER_SLOTS)-1:0]];
            oevt_reg  <= evts[best.idx[$clog2(TIMER_SLOTS)-1:0]];
            last_reg  <= 1'b0;
        end
        else if (acc)
        begin
            otgt_reg <= '0;
            oevt_reg <= '0;
            last_reg <= 1'b1;
            if (command == CMD_CREATE)
            begin
                kind_reg  <= any_free ? KIND_CREATED : KIND_NOFREE;
                oslot_reg <= any_free ? free_idx[3:0] : 4'd0;
            end
            else
            begin
                kind_reg  <= KIND_CANCELLED;
                oslot_reg <= slot;
            end
        end
    end

    // the expiry is final when no due bit is left or the limit is reached
    assign more_due  = |dues;
    assign last_flag = last_reg;

    assign out_valid  = ov_reg && (state_reg == ST_OUT);
    assign kind       = kind_reg;
    assign out_slot   = oslot_reg;
    assign out_target = otgt_reg;
    assign out_event  = oevt_reg;
    assign last       = (kind_reg == KIND_EXPIRED)
                        ? (!more_due || cnt_reg == 5'(RESULT_LIMIT))
                        : last_flag;

    assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> state_reg == ST_IDLE)
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire |-> !ctl.create && !ctl.cancel)
        else $error("fire collides with command");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("result dropped");

endmodule
